// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// types, token kind codes, keyword table and decode functions shared by the
// source text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int LENGTH_BITS_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;
   localparam int PREFIX_BYTES      = 7;
   localparam int KEYWORD_COUNT     = 25;
   localparam int RSP_DEPTH         = 4;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [31:0] token_start;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    word0;
      rsp_type    word1;
   } stt_emit_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_OPER   = 2'd3
   } stt_mode_type;

   localparam logic [1:0] PEND_EQ   = 2'd0;
   localparam logic [1:0] PEND_LT   = 2'd1;
   localparam logic [1:0] PEND_GT   = 2'd2;
   localparam logic [1:0] PEND_BANG = 2'd3;

   localparam logic [5:0] KIND_ILLEGAL  = 6'd0;
   localparam logic [5:0] KIND_IDENT    = 6'd1;
   localparam logic [5:0] KIND_NUMBER   = 6'd2;
   localparam logic [5:0] KIND_EQ_EQ    = 6'd3;
   localparam logic [5:0] KIND_LT       = 6'd4;
   localparam logic [5:0] KIND_GT       = 6'd5;
   localparam logic [5:0] KIND_LT_EQ    = 6'd6;
   localparam logic [5:0] KIND_GT_EQ    = 6'd7;
   localparam logic [5:0] KIND_BANG_EQ  = 6'd8;
   localparam logic [5:0] KIND_BANG     = 6'd9;
   localparam logic [5:0] KIND_LPAREN   = 6'd10;
   localparam logic [5:0] KIND_RPAREN   = 6'd11;
   localparam logic [5:0] KIND_LBRACE   = 6'd12;
   localparam logic [5:0] KIND_RBRACE   = 6'd13;
   localparam logic [5:0] KIND_LBRACKET = 6'd14;
   localparam logic [5:0] KIND_RBRACKET = 6'd15;
   localparam logic [5:0] KIND_COLON    = 6'd16;
   localparam logic [5:0] KIND_COMMA    = 6'd17;
   localparam logic [5:0] KIND_SEMI     = 6'd18;
   localparam logic [5:0] KIND_QUOTE    = 6'd19;
   localparam logic [5:0] KIND_ASSIGN   = 6'd20;
   localparam logic [5:0] KIND_AT       = 6'd21;
   localparam logic [5:0] KIND_STAR     = 6'd22;
   localparam logic [5:0] KIND_PLUS     = 6'd23;
   localparam logic [5:0] KIND_MINUS    = 6'd24;
   localparam logic [5:0] KIND_SLASH    = 6'd25;
   localparam logic [5:0] KIND_PERCENT  = 6'd26;
   localparam logic [5:0] KIND_KW_BASE  = 6'd27;

   localparam logic [55:0] KW_TEXT [KEYWORD_COUNT] = '{
      56'h70726f63,       56'h696e636c756465, 56'h6c6574,         56'h737472756374,
      56'h656e756d,       56'h6966,           56'h656c7365,       56'h7768696c65,
      56'h666f72,         56'h646f,           56'h72657475726e,   56'h7538,
      56'h753136,         56'h753332,         56'h753634,         56'h6938,
      56'h693136,         56'h693332,         56'h693634,         56'h663332,
      56'h663634,         56'h6368617238,     56'h636861723136,   56'h636861723332,
      56'h737472696e67
   };

   localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
      3'd4, 3'd7, 3'd3, 3'd6, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2,
      3'd6, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd5, 3'd6, 3'd6, 3'd6
   };

   function automatic logic [5:0] single_op_kind(input logic [7:0] c);
      logic [5:0] kind;
      unique case (c)
         8'h3c:   kind = KIND_LT;
         8'h3e:   kind = KIND_GT;
         8'h21:   kind = KIND_BANG;
         8'h28:   kind = KIND_LPAREN;
         8'h29:   kind = KIND_RPAREN;
         8'h7b:   kind = KIND_LBRACE;
         8'h7d:   kind = KIND_RBRACE;
         8'h5b:   kind = KIND_LBRACKET;
         8'h5d:   kind = KIND_RBRACKET;
         8'h3a:   kind = KIND_COLON;
         8'h2c:   kind = KIND_COMMA;
         8'h3b:   kind = KIND_SEMI;
         8'h22:   kind = KIND_QUOTE;
         8'h3d:   kind = KIND_ASSIGN;
         8'h40:   kind = KIND_AT;
         8'h2a:   kind = KIND_STAR;
         8'h2b:   kind = KIND_PLUS;
         8'h2d:   kind = KIND_MINUS;
         8'h2f:   kind = KIND_SLASH;
         8'h25:   kind = KIND_PERCENT;
         default: kind = KIND_ILLEGAL;
      endcase
      return kind;
   endfunction

   function automatic logic [5:0] oper_kind(input logic [1:0] pend);
      logic [5:0] kind;
      unique case (pend)
         PEND_EQ:   kind = KIND_ASSIGN;
         PEND_LT:   kind = KIND_LT;
         PEND_GT:   kind = KIND_GT;
         PEND_BANG: kind = KIND_BANG;
         default:   kind = KIND_ILLEGAL;
      endcase
      return kind;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [1:0] pend);
      logic [5:0] kind;
      unique case (pend)
         PEND_EQ:   kind = KIND_EQ_EQ;
         PEND_LT:   kind = KIND_LT_EQ;
         PEND_GT:   kind = KIND_GT_EQ;
         PEND_BANG: kind = KIND_BANG_EQ;
         default:   kind = KIND_ILLEGAL;
      endcase
      return kind;
   endfunction

   // len_short: length is at most the prefix size
   function automatic logic [5:0] keyword_kind(input logic [55:0] prefix,
                                               input logic        len_short,
                                               input logic [2:0]  len3);
      logic [5:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (len_short && len3 == KW_LEN[k] && prefix == KW_TEXT[k]) begin
            kind = KIND_KW_BASE + 6'(k);
         end
      end
      return kind;
   endfunction

endpackage

// ===== sv/stt_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// stt_rsp_fifo
// small result queue, takes up to two words a cycle, hands out one
// ----------------------------------------------------------------------------
module stt_rsp_fifo
   import stt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  stt_emit_type emit,
   output logic         space_ok,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam int PTR_BITS = $clog2(RSP_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   rsp_type               mem_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic                  pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= CNT_BITS'(RSP_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(emit.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(emit.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= emit.word0;
      end
      if (emit.count == 2'd2) begin
         mem_ff[wr_next] <= emit.word1;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_push_space: assert property (@(posedge clock) disable iff (reset)
      emit.count != 2'd0 |-> count_ff <= CNT_BITS'(RSP_DEPTH - 2))
      else $error("push without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && emit.count == 2'd0 |=> count_ff == $past(count_ff) - CNT_BITS'(1))
      else $error("pop did not drop count");
`endif

endmodule

// ===== sv/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// input register, scanner state and the per-byte token step
// ----------------------------------------------------------------------------
module stt_scan
   import stt_pkg::*;
#(
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  logic         space_ok,
   output stt_emit_type emit
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_data_ff;
   stt_mode_type             mode_ff, mode_in, mode_b;
   logic                     dot_ff, dot_in, dot_b;
   logic [1:0]               pend_ff, pend_in, pend_b;
   logic [55:0]              prefix_ff, prefix_in, prefix_b;
   logic [LENGTH_BITS-1:0]   len_ff, len_in, len_b, len_inc;
   logic [POSITION_BITS-1:0] start_ff, start_in, start_b;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic       fire, last;
   logic [7:0] c;
   logic       is_letter, is_digit, is_dot, is_eq, is_space, is_pend;
   logic       ident_start, ident_char;
   logic       extend, pair, close_a, start_new, single, close_c;
   logic [1:0] pend_code;
   logic [5:0] kind_a, kind_c;
   rsp_type    r_a, r_b, r_c;

   assign fire      = in_valid_ff && space_ok;
   assign req_ready = !in_valid_ff || fire;
   assign c         = in_data_ff.char_code;
   assign last      = in_data_ff.end_of_text;

   // character classes
   assign is_letter   = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   assign is_digit    = (c >= 8'h30 && c <= 8'h39);
   assign is_dot      = (c == 8'h2e);
   assign is_eq       = (c == 8'h3d);
   assign is_space    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   assign is_pend     = is_eq || c == 8'h3c || c == 8'h3e || c == 8'h21;
   assign ident_start = is_letter || c == 8'h5f;
   assign ident_char  = ident_start || is_digit;
   assign len_inc     = (len_ff != LEN_MAX) ? len_ff + LENGTH_BITS'(1) : len_ff;

   always_comb begin
      priority if (is_eq) begin
         pend_code = PEND_EQ;
      end else if (c == 8'h3c) begin
         pend_code = PEND_LT;
      end else if (c == 8'h3e) begin
         pend_code = PEND_GT;
      end else begin
         pend_code = PEND_BANG;
      end
   end

   assign extend    = (mode_ff == MODE_IDENT && ident_char) ||
                      (mode_ff == MODE_NUMBER && (is_digit || (is_dot && !dot_ff)));
   assign pair      = (mode_ff == MODE_OPER) && is_eq;
   assign close_a   = (mode_ff != MODE_IDLE) && !extend && !pair;
   assign start_new = !extend && !pair && !is_space;
   assign single    = start_new && !ident_start && !is_digit && !is_pend;

   // state after the byte, before the end mark
   always_comb begin
      mode_b   = mode_ff;
      dot_b    = dot_ff;
      pend_b   = pend_ff;
      prefix_b = prefix_ff;
      len_b    = len_ff;
      start_b  = start_ff;
      if (extend) begin
         if (mode_ff == MODE_IDENT && len_ff < LENGTH_BITS'(PREFIX_BYTES)) begin
            prefix_b = {prefix_ff[47:0], c};
         end
         if (mode_ff == MODE_NUMBER && is_dot) begin
            dot_b = 1'b1;
         end
         len_b = len_inc;
      end
      if (pair) begin
         mode_b = MODE_IDLE;
         pend_b = PEND_EQ;
         len_b  = '0;
      end
      if (close_a) begin
         mode_b   = MODE_IDLE;
         dot_b    = 1'b0;
         pend_b   = PEND_EQ;
         prefix_b = '0;
         len_b    = '0;
      end
      if (start_new) begin
         start_b = pos_ff;
         priority if (ident_start) begin
            mode_b   = MODE_IDENT;
            prefix_b = {48'd0, c};
            len_b    = LENGTH_BITS'(1);
         end else if (is_digit) begin
            mode_b = MODE_NUMBER;
            dot_b  = 1'b0;
            len_b  = LENGTH_BITS'(1);
         end else if (is_pend) begin
            mode_b = MODE_OPER;
            pend_b = pend_code;
            len_b  = LENGTH_BITS'(1);
         end else begin
            mode_b = MODE_IDLE;
         end
      end
   end

   assign close_c = last && (mode_b != MODE_IDLE);

   // next state
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      mode_in   = mode_ff;
      dot_in    = dot_ff;
      pend_in   = pend_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      if (fire) begin
         if (last) begin
            mode_in   = MODE_IDLE;
            dot_in    = 1'b0;
            pend_in   = PEND_EQ;
            prefix_in = '0;
            len_in    = '0;
            start_in  = '0;
            pos_in    = '0;
         end else begin
            mode_in   = mode_b;
            dot_in    = dot_b;
            pend_in   = pend_b;
            prefix_in = prefix_b;
            len_in    = len_b;
            start_in  = start_b;
            pos_in    = pos_ff + POSITION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         dot_ff      <= 1'b0;
         pend_ff     <= PEND_EQ;
         prefix_ff   <= '0;
         len_ff      <= '0;
         start_ff    <= '0;
         pos_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         dot_ff      <= dot_in;
         pend_ff     <= pend_in;
         prefix_ff   <= prefix_in;
         len_ff      <= len_in;
         start_ff    <= start_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // emitted words
   always_comb begin
      unique case (mode_ff)
         MODE_IDENT:  kind_a = keyword_kind(prefix_ff, len_ff <= LENGTH_BITS'(PREFIX_BYTES),
                                            len_ff[2:0]);
         MODE_NUMBER: kind_a = KIND_NUMBER;
         MODE_OPER:   kind_a = pair ? pair_kind(pend_ff) : oper_kind(pend_ff);
         default:     kind_a = KIND_ILLEGAL;
      endcase
      unique case (mode_b)
         MODE_IDENT:  kind_c = keyword_kind(prefix_b, len_b <= LENGTH_BITS'(PREFIX_BYTES),
                                            len_b[2:0]);
         MODE_NUMBER: kind_c = KIND_NUMBER;
         MODE_OPER:   kind_c = oper_kind(pend_b);
         default:     kind_c = KIND_ILLEGAL;
      endcase

      r_a.token_kind   = kind_a;
      r_a.token_start  = 32'(start_ff);
      r_a.token_length = pair ? 16'd2 : 16'(len_ff);
      r_a.last_of_run  = 1'b0;

      r_b.token_kind   = single_op_kind(c);
      r_b.token_start  = 32'(pos_ff);
      r_b.token_length = 16'd1;
      r_b.last_of_run  = 1'b0;

      r_c.token_kind   = kind_c;
      r_c.token_start  = 32'(start_b);
      r_c.token_length = 16'(len_b);
      r_c.last_of_run  = 1'b0;

      emit.count = 2'd0;
      if (fire) begin
         emit.count = 2'(close_a || pair) + 2'(single) + 2'(close_c);
      end
      priority if (close_a || pair) begin
         emit.word0 = r_a;
      end else if (single) begin
         emit.word0 = r_b;
      end else begin
         emit.word0 = r_c;
      end
      emit.word1 = ((close_a || pair) && single) ? r_b : r_c;
      emit.word0.last_of_run = (emit.count == 2'd1);
      emit.word1.last_of_run = 1'b1;
   end

`ifndef ASSERT_OFF
   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> len_ff == '0)
      else $error("idle scanner holds a length");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      fire && last |=> pos_ff == '0 && mode_ff == MODE_IDLE)
      else $error("end mark did not restart offsets");

   a_double_tag: assert property (@(posedge clock) disable iff (reset)
      emit.count == 2'd2 |-> !emit.word0.last_of_run && emit.word1.last_of_run)
      else $error("double emission tagged wrong");
`endif

endmodule

// ===== sv/source_text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// byte-serial lexical analyzer: identifiers, numbers, operators, keywords
// ----------------------------------------------------------------------------
// req channel carries one text byte per word plus an end-of-text flag; the
// rsp channel carries finished tokens (kind, start offset, length) with
// last_of_run marking the final token a byte produced. A byte yields zero,
// one or two tokens.
// A byte accepted into the input register is scanned from there; its tokens
// are written into the result queue when the scanner fires and show on rsp
// from the queue. One byte per cycle is taken while the queue has room; the
// four-word result queue absorbs double emissions, and the scanner stalls a
// byte only while the queue has fewer than two free words.
// When the receiver stalls, words stay queued and req_ready drops once the
// input register is full and the queue has fewer than two free words;
// nothing is lost.
// Reset clears scanner state, offsets and the queue. An end-of-text byte
// flushes any open token and restarts offsets at zero.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top
   import stt_pkg::*;
#(
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   stt_emit_type emit;
   logic         space_ok;

   stt_scan #(
      .LENGTH_BITS   (LENGTH_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .space_ok  (space_ok),
      .emit      (emit)
   );

   stt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
